// ===== rtl/priority_task_scheduler_with_events_unit_macros.svh =====
// assertion macros for the task scheduler checker
`ifndef PRIORITY_TASK_SCHEDULER_WITH_EVENTS_UNIT_MACROS_SVH
`define PRIORITY_TASK_SCHEDULER_WITH_EVENTS_UNIT_MACROS_SVH

// generic clocked assertion, off while in reset
`define PTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// consequent checked in the same cycle
`define PTS_ASSERT_NOW(lbl, ante, cons, msg) `PTS_ASSERT(lbl, ante |-> cons, msg)

// consequent checked in the next cycle
`define PTS_ASSERT_NEXT(lbl, ante, cons, msg) `PTS_ASSERT(lbl, ante |=> cons, msg)

`endif

// ===== rtl/pts_pkg.sv =====
// shared types and constants of the task scheduler
package pts_pkg;

  localparam int unsigned NumReady  = 4;
  localparam int unsigned NumWait   = 3;
  localparam int unsigned NumQueues = 7;
  localparam int unsigned NumIds    = 16;
  localparam int unsigned IdW       = 4;
  localparam int unsigned PrioW     = 2;
  localparam int unsigned QW        = 3;

  localparam logic [QW-1:0] WaitBase = 3'd4;

  typedef enum logic [2:0] {
    CMD_ADD     = 3'd0,
    CMD_RELEASE = 3'd1,
    CMD_BLOCK   = 3'd2,
    CMD_EVENT   = 3'd3,
    CMD_EXIT    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    EV_TICK = 2'd0,
    EV_OUT  = 2'd1,
    EV_IN   = 2'd2
  } ev_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WPOP,
    S_WPUSH,
    S_PUSH,
    S_PICK,
    S_LOAD,
    S_DONE
  } state_e;

  typedef struct packed {
    logic          push;
    logic          pop;
    logic [QW-1:0] q;
  } qop_t;

  typedef struct packed {
    logic [NumQueues-1:0] full;
    logic [NumQueues-1:0] empty;
  } qstat_t;

endpackage

// ===== rtl/pts_qmem.sv =====
// single-port id store shared by all ready and wait queues
module pts_qmem #(
  parameter int unsigned AddrW = 7,
  parameter int unsigned Depth = 112
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic                    re_i,
  input  logic [AddrW-1:0]        addr_i,
  input  logic [pts_pkg::IdW-1:0] wdata_i,
  output logic [pts_pkg::IdW-1:0] rdata_o
);
  import pts_pkg::*;

  logic [IdW-1:0] mem_q [Depth];
  logic [IdW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pts_qptr.sv =====
// head, tail and fill count of every queue, one push or pop per cycle
module pts_qptr #(
  parameter int unsigned MaxTasks = 16,
  localparam int unsigned PtrW = $clog2(MaxTasks),
  localparam int unsigned CntW = $clog2(MaxTasks + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pts_pkg::qop_t   op_i,
  output logic [PtrW-1:0] ptr_o,
  output pts_pkg::qstat_t stat_o
);
  import pts_pkg::*;

  logic [PtrW-1:0] head_q [NumQueues];
  logic [PtrW-1:0] head_d [NumQueues];
  logic [PtrW-1:0] tail_q [NumQueues];
  logic [PtrW-1:0] tail_d [NumQueues];
  logic [CntW-1:0] cnt_q  [NumQueues];
  logic [CntW-1:0] cnt_d  [NumQueues];
  logic [PtrW-1:0] ptr_nxt;

  always_comb begin
    for (int i = 0; i < NumQueues; i++) begin
      stat_o.full[i]  = (cnt_q[i] == CntW'(MaxTasks));
      stat_o.empty[i] = (cnt_q[i] == '0);
    end
  end

  assign ptr_o   = op_i.push ? tail_q[op_i.q] : head_q[op_i.q];
  assign ptr_nxt = (ptr_o == PtrW'(MaxTasks - 1)) ? '0 : ptr_o + 1'b1;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (op_i.push && !stat_o.full[op_i.q]) begin
      tail_d[op_i.q] = ptr_nxt;
      cnt_d[op_i.q]  = cnt_q[op_i.q] + 1'b1;
    end else if (op_i.pop && !stat_o.empty[op_i.q]) begin
      head_d[op_i.q] = ptr_nxt;
      cnt_d[op_i.q]  = cnt_q[op_i.q] - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumQueues; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== rtl/priority_task_scheduler_with_events_unit.sv =====
// top level of the fixed-priority task scheduler with event wait queues
//
// a command word is taken at a rising edge with start high and busy low;
// cmd_i, task_id_i, task_priority_i and event_req_i are sampled there.
// busy stays high until the result word has been shown. the result stands
// on current_task_o and the flag outputs for one cycle with valid_o high;
// the receiver cannot stall it and must take it in that cycle.
// the command runs as a short sequence of queue steps: each step is one
// push or one pop through the shared pointer unit and the single-port
// queue store, so at most one queue operation happens per cycle. steps:
// a no-op or a block with a saved signal goes to done; add pushes the
// task; exit picks, then loads if a task is ready; release and block push
// the running task, then pick; event first readies any waiting task.
// reset clears all queue pointers and counts, the running task (task 0)
// and both saved-signal flags; the queue store and the priority table
// hold nothing valid until written and need no clearing pass.
module priority_task_scheduler_with_events_unit #(
  parameter int unsigned MaxTasks = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                cmd_i,
  input  logic [pts_pkg::IdW-1:0]   task_id_i,
  input  logic [pts_pkg::PrioW-1:0] task_priority_i,
  input  logic [1:0]                event_req_i,
  output logic                      valid_o,
  output logic [pts_pkg::IdW-1:0]   current_task_o,
  output logic                      switched_o,
  output logic                      no_task_o,
  output logic                      signal_lost_o,
  output logic                      queue_full_o
);
  import pts_pkg::*;

  localparam int unsigned PtrW     = $clog2(MaxTasks);
  localparam int unsigned AddrW    = QW + PtrW;
  localparam int unsigned MemDepth = NumQueues * (2 ** PtrW);

  state_e state_q, state_d;

  logic [2:0]       cmd_q;
  logic [IdW-1:0]   id_q;
  logic [PrioW-1:0] prio_q;
  logic [1:0]       ev_q;
  logic [PrioW-1:0] ptab_q [NumIds];

  logic [IdW-1:0] run_q;
  logic           out_saved_q, in_saved_q;
  logic           sw_q, none_q, lost_q, full_q;

  qop_t            op;
  qstat_t          qstat;
  logic [PtrW-1:0] ptr;
  logic [IdW-1:0]  rdata;
  logic [IdW-1:0]  push_id;
  logic [IdW-1:0]  ptab_addr;
  logic [PrioW-1:0] ptab_rd;
  logic [1:0]      pick_idx;
  logic            rdy_any;
  logic            accept;
  logic            ev_ok_i;
  logic [QW-1:0]   wq_i, wq_q;
  logic            saved_hit_i;

  assign accept  = start && (state_q == S_IDLE);
  assign ev_ok_i = event_req_i inside {EV_TICK, EV_OUT, EV_IN};
  assign wq_i    = WaitBase + QW'(event_req_i);
  assign wq_q    = WaitBase + QW'(ev_q);
  assign saved_hit_i = (event_req_i == EV_OUT && out_saved_q) ||
                       (event_req_i == EV_IN && in_saved_q);

  assign rdy_any = !(&qstat.empty[NumReady-1:0]);

  always_comb begin
    pick_idx = 2'd3;
    if (!qstat.empty[2]) pick_idx = 2'd2;
    if (!qstat.empty[1]) pick_idx = 2'd1;
    if (!qstat.empty[0]) pick_idx = 2'd0;
  end

  assign ptab_addr = (state_q == S_WPUSH) ? rdata : run_q;
  assign ptab_rd   = ptab_q[ptab_addr];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (cmd_i)
            CMD_ADD, CMD_RELEASE: state_d = S_PUSH;
            CMD_BLOCK: begin
              if (!ev_ok_i || saved_hit_i) state_d = S_DONE;
              else state_d = S_PUSH;
            end
            CMD_EVENT: begin
              if (!ev_ok_i) state_d = S_DONE;
              else if (!qstat.empty[wq_i]) state_d = S_WPOP;
              else state_d = S_PUSH;
            end
            CMD_EXIT: state_d = S_PICK;
            default:  state_d = S_DONE;
          endcase
        end
      end
      S_WPOP:  state_d = S_WPUSH;
      S_WPUSH: state_d = S_PUSH;
      S_PUSH:  state_d = (cmd_q == CMD_ADD) ? S_DONE : S_PICK;
      S_PICK:  state_d = rdy_any ? S_LOAD : S_DONE;
      S_LOAD:  state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // queue operation of each step
  always_comb begin
    op      = '0;
    push_id = run_q;
    case (state_q)
      S_WPOP: begin
        op.pop = 1'b1;
        op.q   = wq_q;
      end
      S_WPUSH: begin
        op.push = 1'b1;
        op.q    = {1'b0, ptab_rd};
        push_id = rdata;
      end
      S_PUSH: begin
        op.push = 1'b1;
        case (cmd_q)
          CMD_ADD: begin
            op.q    = {1'b0, prio_q};
            push_id = id_q;
          end
          CMD_BLOCK: op.q = wq_q;
          default:   op.q = {1'b0, ptab_rd};
        endcase
      end
      S_PICK: begin
        op.pop = rdy_any;
        op.q   = {1'b0, pick_idx};
      end
      default: op = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      run_q       <= '0;
      out_saved_q <= 1'b0;
      in_saved_q  <= 1'b0;
      sw_q        <= 1'b0;
      none_q      <= 1'b0;
      lost_q      <= 1'b0;
      full_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        sw_q   <= 1'b0;
        none_q <= 1'b0;
        lost_q <= 1'b0;
        full_q <= 1'b0;
        if (cmd_i == CMD_BLOCK) begin
          if (event_req_i == EV_OUT && out_saved_q) out_saved_q <= 1'b0;
          if (event_req_i == EV_IN && in_saved_q) in_saved_q <= 1'b0;
        end
        if (cmd_i == CMD_EVENT && ev_ok_i && qstat.empty[wq_i]) begin
          if (event_req_i == EV_OUT) begin
            lost_q      <= out_saved_q;
            out_saved_q <= 1'b1;
          end
          if (event_req_i == EV_IN) begin
            lost_q     <= in_saved_q;
            in_saved_q <= 1'b1;
          end
        end
      end
      if (op.push && qstat.full[op.q]) full_q <= 1'b1;
      if (state_q == S_PICK && !rdy_any) none_q <= 1'b1;
      if (state_q == S_LOAD) begin
        run_q <= rdata;
        sw_q  <= 1'b1;
      end
    end
  end

  // command word and priority table
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_i;
      id_q   <= task_id_i;
      prio_q <= task_priority_i;
      ev_q   <= event_req_i;
      if (cmd_i == CMD_ADD) ptab_q[task_id_i] <= task_priority_i;
    end
  end

  pts_qptr #(
    .MaxTasks(MaxTasks)
  ) u_qptr (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .op_i  (op),
    .ptr_o (ptr),
    .stat_o(qstat)
  );

  pts_qmem #(
    .AddrW(AddrW),
    .Depth(MemDepth)
  ) u_qmem (
    .clk_i  (clk_i),
    .we_i   (op.push && !qstat.full[op.q]),
    .re_i   (op.pop),
    .addr_i ({op.q, ptr}),
    .wdata_i(push_id),
    .rdata_o(rdata)
  );

  assign busy           = (state_q != S_IDLE);
  assign valid_o        = (state_q == S_DONE);
  assign current_task_o = run_q;
  assign switched_o     = sw_q;
  assign no_task_o      = none_q;
  assign signal_lost_o  = lost_q;
  assign queue_full_o   = full_q;

endmodule

// ===== rtl/pts_checker.sv =====
// port-level checks of the task scheduler and their binding
`include "priority_task_scheduler_with_events_unit_macros.svh"

module pts_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start,
  input logic                    busy,
  input logic                    valid_o,
  input logic [pts_pkg::IdW-1:0] current_task_o,
  input logic                    switched_o,
  input logic                    no_task_o
);

  `PTS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `PTS_ASSERT_NEXT(a_one_result, valid_o, !valid_o && !busy, "result not single or busy held")
  `PTS_ASSERT_NOW(a_result_busy, valid_o, busy, "result shown while idle")
  `PTS_ASSERT_NOW(a_flags_excl, valid_o, !(switched_o && no_task_o), "switched and no_task both")
  `PTS_ASSERT_NOW(a_task_kept, valid_o && !switched_o, $stable(current_task_o), "task moved")

endmodule

bind priority_task_scheduler_with_events_unit pts_checker u_pts_checker (.*);

// ===== test/priority_task_scheduler_with_events_unit_test.sv =====
// testbench for the priority task scheduler: random command words checked against a predictor
`timescale 1ns / 1ps

module priority_task_scheduler_with_events_unit_test;
  import pts_pkg::*;

  localparam int unsigned MaxTasks = 16;
  localparam int unsigned WordTarget = 1050;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned MaxPrinted = 30;
  localparam logic [1:0] EvUnknown = 2'd3;
  localparam logic [2:0] CmdUnusedLo = 3'd5;
  localparam logic [2:0] CmdUnusedHi = 3'd7;

  typedef struct packed {
    logic [2:0] cmd;
    logic [3:0] id;
    logic [1:0] prio;
    logic [1:0] ev;
  } sched_word_t;

  typedef struct packed {
    logic [3:0] current;
    logic       switched;
    logic       none;
    logic       lost;
    logic       full;
  } sched_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] cmd_i = '0;
  logic [IdW-1:0] task_id_i = '0;
  logic [PrioW-1:0] task_priority_i = '0;
  logic [1:0] event_req_i = '0;
  logic valid_o;
  logic [IdW-1:0] current_task_o;
  logic switched_o;
  logic no_task_o;
  logic signal_lost_o;
  logic queue_full_o;

  priority_task_scheduler_with_events_unit #(
    .MaxTasks(MaxTasks)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .cmd_i(cmd_i),
    .task_id_i(task_id_i),
    .task_priority_i(task_priority_i),
    .event_req_i(event_req_i),
    .valid_o(valid_o),
    .current_task_o(current_task_o),
    .switched_o(switched_o),
    .no_task_o(no_task_o),
    .signal_lost_o(signal_lost_o),
    .queue_full_o(queue_full_o)
  );

  sched_word_t queued_commands[$];
  sched_result_t awaited_reports[$];
  int unsigned commands_total = 0;
  int unsigned useful_commands = 0;
  int unsigned commands_taken = 0;
  int unsigned reports_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned n_switch = 0;
  int unsigned n_empty = 0;
  int unsigned n_lost = 0;
  int unsigned n_full = 0;

  // scheduler state as the predictor sees it
  logic [3:0] slots [NumQueues][MaxTasks];
  int unsigned head_at [NumQueues] = '{default: 0};
  int unsigned fill [NumQueues] = '{default: 0};
  logic [1:0] urgency [NumIds];
  logic [3:0] running = '0;
  bit out_saved = 1'b0;
  bit in_saved = 1'b0;

  bit word_taken = 1'b0;
  int unsigned burst_left = 0;
  int unsigned idle_left = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit push_task(int unsigned q, logic [3:0] id);
    if (fill[q] >= MaxTasks) return 1'b1;
    slots[q][(head_at[q] + fill[q]) % MaxTasks] = id;
    fill[q]++;
    return 1'b0;
  endfunction

  function automatic logic [3:0] pop_task(int unsigned q);
    logic [3:0] id;
    id = slots[q][head_at[q]];
    head_at[q] = (head_at[q] + 1) % MaxTasks;
    fill[q]--;
    return id;
  endfunction

  function automatic bit make_ready(logic [3:0] id);
    return push_task(int'(urgency[id]), id);
  endfunction

  function automatic bit take_next();
    for (int unsigned q = 0; q < NumReady; q++) begin
      if (fill[q] != 0) begin
        running = pop_task(q);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void schedule_command(sched_word_t w);
    sched_result_t r;
    logic [3:0] woken;
    int unsigned wq;
    r = '0;
    wq = int'(WaitBase) + int'(w.ev);
    case (w.cmd)
      CMD_ADD: begin
        urgency[w.id] = w.prio;
        r.full = make_ready(w.id);
      end
      CMD_RELEASE: begin
        r.full = make_ready(running);
        r.switched = take_next();
        r.none = !r.switched;
      end
      CMD_BLOCK: begin
        if (w.ev == EvUnknown) begin
        end else if (w.ev == EV_OUT && out_saved) begin
          out_saved = 1'b0;
        end else if (w.ev == EV_IN && in_saved) begin
          in_saved = 1'b0;
        end else begin
          r.full = push_task(wq, running);
          r.switched = take_next();
          r.none = !r.switched;
        end
      end
      CMD_EVENT: begin
        if (w.ev != EvUnknown) begin
          if (fill[wq] != 0) begin
            woken = pop_task(wq);
            r.full = make_ready(woken);
          end else if (w.ev == EV_OUT) begin
            r.lost = out_saved;
            out_saved = 1'b1;
          end else if (w.ev == EV_IN) begin
            r.lost = in_saved;
            in_saved = 1'b1;
          end
          if (make_ready(running)) r.full = 1'b1;
          r.switched = take_next();
          r.none = !r.switched;
        end
      end
      CMD_EXIT: begin
        r.switched = take_next();
        r.none = !r.switched;
      end
      default: begin
      end
    endcase
    r.current = running;
    n_switch += r.switched;
    n_empty += r.none;
    n_lost += r.lost;
    n_full += r.full;
    awaited_reports.push_back(r);
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= MaxPrinted) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic queue_word(logic [2:0] c, logic [3:0] id, logic [1:0] p, logic [1:0] e);
    sched_word_t w;
    w = '{c, id, p, e};
    queued_commands.push_back(w);
    commands_total++;
    if (c <= CMD_EXIT && !((c == CMD_BLOCK || c == CMD_EVENT) && e == EvUnknown)) begin
      useful_commands++;
    end
  endtask

  function automatic logic [1:0] rand_ev();
    return ($urandom_range(0, 15) == 0) ? EvUnknown : 2'($urandom_range(0, 2));
  endfunction

  // driver: bursts of words with random idle gaps
  always @(negedge clk_i) begin : driver
    sched_word_t w;
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !word_taken) begin
    end else if (idle_left > 0 || queued_commands.size() == 0) begin
      if (idle_left > 0) idle_left <= idle_left - 1;
      start <= 1'b0;
      cmd_i <= 3'($urandom);
      task_id_i <= 4'($urandom);
      task_priority_i <= 2'($urandom);
      event_req_i <= 2'($urandom);
    end else begin
      w = queued_commands.pop_front();
      start <= 1'b1;
      cmd_i <= w.cmd;
      task_id_i <= w.id;
      task_priority_i <= w.prio;
      event_req_i <= w.ev;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        idle_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // monitor: check each result word, then predict the word taken at this edge
  always @(posedge clk_i) begin : monitor
    sched_result_t want;
    if (rst_ni) begin
      if (valid_o) begin
        reports_seen++;
        if (awaited_reports.size() == 0) begin
          report_mismatch($sformatf("result word with none awaited, task %0d", current_task_o));
        end else begin
          want = awaited_reports.pop_front();
          if (current_task_o !== want.current)
            report_mismatch($sformatf("word %0d current_task got %0d want %0d",
                                      reports_seen, current_task_o, want.current));
          if (switched_o !== want.switched)
            report_mismatch($sformatf("word %0d switched got %0b want %0b",
                                      reports_seen, switched_o, want.switched));
          if (no_task_o !== want.none)
            report_mismatch($sformatf("word %0d no_task got %0b want %0b",
                                      reports_seen, no_task_o, want.none));
          if (signal_lost_o !== want.lost)
            report_mismatch($sformatf("word %0d signal_lost got %0b want %0b",
                                      reports_seen, signal_lost_o, want.lost));
          if (queue_full_o !== want.full)
            report_mismatch($sformatf("word %0d queue_full got %0b want %0b",
                                      reports_seen, queue_full_o, want.full));
        end
      end
      if (start && !busy) begin
        schedule_command('{cmd_i, task_id_i, task_priority_i, event_req_i});
        commands_taken++;
      end
    end
    word_taken <= rst_ni && start && !busy;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    int unsigned m;
    logic [1:0] p;
    logic [1:0] e;
    // nothing read from the priority table before task 0 is added
    queue_word(CMD_EXIT, 4'd15, 2'd3, EvUnknown);
    queue_word(CmdUnusedLo, 4'd0, 2'd0, EV_TICK);
    queue_word(CmdUnusedHi, 4'd15, 2'd3, EvUnknown);
    queue_word(CMD_BLOCK, 4'd0, 2'd0, EvUnknown);
    queue_word(CMD_EVENT, 4'd15, 2'd3, EvUnknown);
    queue_word(CMD_ADD, 4'd0, 2'd0, EV_TICK);
    queue_word(CMD_ADD, 4'd15, 2'd3, EV_IN);
    queue_word(CMD_ADD, 4'd5, 2'd1, EV_OUT);
    queue_word(CMD_ADD, 4'd10, 2'd2, EvUnknown);
    queue_word(CMD_RELEASE, 4'd3, 2'd2, EV_TICK);
    queue_word(CMD_BLOCK, 4'd12, 2'd1, EV_TICK);
    queue_word(CMD_BLOCK, 4'd9, 2'd0, EV_OUT);
    queue_word(CMD_EVENT, 4'd6, 2'd3, EV_OUT);
    queue_word(CMD_EVENT, 4'd1, 2'd2, EV_IN);
    queue_word(CMD_EVENT, 4'd14, 2'd1, EV_IN);
    queue_word(CMD_BLOCK, 4'd7, 2'd0, EV_IN);
    queue_word(CMD_EVENT, 4'd8, 2'd3, EV_TICK);
    queue_word(CMD_EVENT, 4'd2, 2'd0, EV_OUT);
    queue_word(CMD_BLOCK, 4'd11, 2'd2, EV_OUT);
    for (int i = 0; i < 5; i++) queue_word(CMD_EXIT, 4'($urandom), 2'($urandom), rand_ev());

    while (useful_commands < WordTarget) begin
      case ($urandom_range(0, 9))
        6: begin
          p = 2'($urandom);
          n = $urandom_range(14, 20);
          for (int i = 0; i < n; i++) queue_word(CMD_ADD, 4'($urandom), p, rand_ev());
          m = $urandom_range(4, 24);
          for (int i = 0; i < m; i++)
            queue_word($urandom_range(0, 1) ? CMD_RELEASE : CMD_EXIT, 4'($urandom),
                       2'($urandom), rand_ev());
        end
        7: begin
          e = 2'($urandom_range(0, 2));
          n = $urandom_range(14, 20);
          for (int i = 0; i < n; i++) queue_word(CMD_BLOCK, 4'($urandom), 2'($urandom), e);
          m = $urandom_range(10, 20);
          for (int i = 0; i < m; i++) queue_word(CMD_EVENT, 4'($urandom), 2'($urandom), e);
        end
        8: begin
          n = $urandom_range(6, 15);
          for (int i = 0; i < n; i++)
            queue_word($urandom_range(0, 1) ? CMD_BLOCK : CMD_EVENT, 4'($urandom),
                       2'($urandom), 2'($urandom_range(1, 3)));
        end
        9: begin
          n = $urandom_range(3, 20);
          for (int i = 0; i < n; i++) queue_word(CMD_EXIT, 4'($urandom), 2'($urandom), rand_ev());
        end
        default: begin
          n = $urandom_range(5, 30);
          for (int i = 0; i < n; i++) begin
            m = $urandom_range(0, 99);
            if (m < 30) queue_word(CMD_ADD, 4'($urandom), 2'($urandom), rand_ev());
            else if (m < 45) queue_word(CMD_RELEASE, 4'($urandom), 2'($urandom), rand_ev());
            else if (m < 65) queue_word(CMD_BLOCK, 4'($urandom), 2'($urandom), rand_ev());
            else if (m < 85) queue_word(CMD_EVENT, 4'($urandom), 2'($urandom), rand_ev());
            else if (m < 97) queue_word(CMD_EXIT, 4'($urandom), 2'($urandom), rand_ev());
            else queue_word(3'($urandom_range(CmdUnusedLo, CmdUnusedHi)), 4'($urandom),
                            2'($urandom), rand_ev());
          end
        end
      endcase
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (commands_taken < commands_total) @(posedge clk_i);
    while (awaited_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("ran %0d command words (%0d with effect) in %0d cycles", commands_total,
             useful_commands, cycle_count);
    $display("expected %0d switches, %0d empty picks, %0d lost signals, %0d dropped pushes",
             n_switch, n_empty, n_lost, n_full);
    if (mismatches == 0 && awaited_reports.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
